/* hdl/cwc_pkg.sv */
package cwc_pkg;

  localparam int SEQ_W    = 32;
  localparam int WIN_W    = 16;
  localparam int DUP_W    = 8;
  localparam int RTT_W    = 28;
  localparam int SAMPLE_W = 24;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 112;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_PEER_SEQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADVERTISED_WINDOW = 1'b1;

  localparam logic [WIN_W-1:0] WIN_MAX       = 16'hFFFF;
  localparam logic [RTT_W-1:0] RTT_MAX       = 28'hFFFFFFF;
  localparam logic [DUP_W-1:0] DUP_MAX       = 8'hFF;
  localparam logic [DUP_W-1:0] DUP_TRIGGER   = 8'd3;
  localparam logic [WIN_W:0]   RECOVERY_ADD  = 17'd3;
  localparam logic [WIN_W-1:0] WIN_ONE       = 16'd1;
  localparam logic [WIN_W-1:0] ADV_WIN_RESET = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACK     = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_START   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED   = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NEW_ACK   = 2'd2,
    ST_RESTART   = 2'd3
  } status_t;

  typedef struct packed {
    logic [SEQ_W-1:0] send_base;
    logic [WIN_W-1:0] cong_window;
    logic [WIN_W-1:0] ss_threshold;
    logic [DUP_W-1:0] dup_acks;
    logic [RTT_W-1:0] rtt_est;
    logic [RTT_W-1:0] rtt_dev;
  } cc_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [SEQ_W-1:0]    ack_seq;
    logic [SEQ_W-1:0]    ack_number;
    logic                ack_flag;
    logic [SAMPLE_W-1:0] rtt_sample;
  } cc_item_t;

  typedef struct packed {
    status_t          ack_status;
    logic [WIN_W-1:0] window;
    logic [WIN_W-1:0] slow_start_threshold;
    logic [WIN_W-1:0] packets_allowed;
    logic [SEQ_W-1:0] send_base_out;
    logic [RTT_W-1:0] retransmit_timeout;
  } cc_result_t;

endpackage

/* hdl/cwc_update.sv */
module cwc_update
  import cwc_pkg::*;
(
  input  cc_state_t        st,
  input  cc_item_t         item,
  input  logic [SEQ_W-1:0] expected_peer_seq,
  input  logic [WIN_W-1:0] advertised_window,
  output cc_state_t        st_nxt,
  output cc_result_t       res
);

  logic [RTT_W-1:0]  est_seed;
  logic [RTT_W:0]    err;
  logic [RTT_W-3:0]  err_abs;
  logic [RTT_W:0]    est_sum;
  logic [RTT_W:0]    dev_sum;
  logic [RTT_W-1:0]  est_new;
  logic [RTT_W-1:0]  dev_new;
  logic [DUP_W-1:0]  dup_inc;
  logic [WIN_W:0]    cw_plus1;
  logic [WIN_W:0]    cw_double;
  logic [WIN_W:0]    half_plus3;
  logic [WIN_W-1:0]  cw_grow;
  logic              valid_ack;

  always_comb begin
    est_seed = (st.rtt_est == '0) ? {{(RTT_W-SAMPLE_W){1'b0}}, item.rtt_sample} : st.rtt_est;
    err = {{(RTT_W+1-SAMPLE_W){1'b0}}, item.rtt_sample} - {4'b0, est_seed[RTT_W-1:3]};
    err_abs = err[RTT_W] ? (RTT_W-2)'(-err) : err[RTT_W-3:0];
    est_sum = {1'b0, est_seed} - {4'b0, est_seed[RTT_W-1:3]}
            + {{(RTT_W+1-SAMPLE_W){1'b0}}, item.rtt_sample};
    dev_sum = {1'b0, st.rtt_dev} - {4'b0, st.rtt_dev[RTT_W-1:3]} + {3'b0, err_abs};
    est_new = est_sum[RTT_W] ? RTT_MAX : est_sum[RTT_W-1:0];
    dev_new = dev_sum[RTT_W] ? RTT_MAX : dev_sum[RTT_W-1:0];

    dup_inc    = (st.dup_acks == DUP_MAX) ? DUP_MAX : st.dup_acks + 8'd1;
    cw_plus1   = {1'b0, st.cong_window} + 17'd1;
    cw_double  = {st.cong_window, 1'b0};
    half_plus3 = {2'b0, st.cong_window[WIN_W-1:1]} + RECOVERY_ADD;
    valid_ack  = item.ack_flag && (item.ack_seq == expected_peer_seq);
    if (cw_double > {1'b0, st.ss_threshold}) begin
      cw_grow = cw_plus1[WIN_W] ? WIN_MAX : cw_plus1[WIN_W-1:0];
    end else begin
      cw_grow = cw_double[WIN_W] ? WIN_MAX : cw_double[WIN_W-1:0];
    end

    st_nxt = st;
    res.ack_status = ST_IGNORED;
    case (item.command)
      CMD_START: begin
        st_nxt.cong_window  = WIN_ONE;
        st_nxt.dup_acks     = '0;
        st_nxt.ss_threshold = advertised_window;
        res.ack_status      = ST_RESTART;
      end
      CMD_TIMEOUT: begin
        st_nxt.ss_threshold = {1'b0, st.cong_window[WIN_W-1:1]};
        st_nxt.cong_window  = WIN_ONE;
        st_nxt.dup_acks     = '0;
        res.ack_status      = ST_RESTART;
      end
      CMD_ACK: begin
        st_nxt.rtt_est = est_new;
        st_nxt.rtt_dev = dev_new;
        if (valid_ack) begin
          if (item.ack_number == st.send_base) begin
            st_nxt.dup_acks = dup_inc;
            if (dup_inc == DUP_TRIGGER) begin
              st_nxt.ss_threshold = {1'b0, st.cong_window[WIN_W-1:1]};
              st_nxt.cong_window  = half_plus3[WIN_W-1:0];
            end else if (dup_inc > DUP_TRIGGER) begin
              st_nxt.cong_window = cw_plus1[WIN_W] ? WIN_MAX : cw_plus1[WIN_W-1:0];
            end
            res.ack_status = ST_DUPLICATE;
          end else begin
            st_nxt.cong_window = (st.dup_acks >= DUP_TRIGGER) ? st.ss_threshold : cw_grow;
            st_nxt.dup_acks    = '0;
            st_nxt.send_base   = item.ack_number;
            res.ack_status     = ST_NEW_ACK;
          end
        end
      end
      default: begin
        res.ack_status = ST_IGNORED;
      end
    endcase

    res.window               = st_nxt.cong_window;
    res.slow_start_threshold = st_nxt.ss_threshold;
    res.packets_allowed      = (st_nxt.cong_window < advertised_window) ?
                               st_nxt.cong_window : advertised_window;
    res.send_base_out        = st_nxt.send_base;
    res.retransmit_timeout   = {3'b0, st_nxt.rtt_est[RTT_W-1:3]}
                             + {1'b0, st_nxt.rtt_dev[RTT_W-1:1]};
  end

endmodule

/* hdl/congestion_window_controller.sv */
// Sender-side congestion window controller in the style of TCP Reno.
// Each input beat carries one event: an ack, a retransmission timeout or a
// start of transfer, selected by in_tuser. Every accepted beat yields exactly
// one output beat with the status, the updated window and threshold, the
// number of packets allowed in flight, the send base and the next
// retransmission timeout.
// The block has an input register and a result register with the update
// logic between them; an accepted beat moves from the input register into
// the result register, where its result is presented, and one beat per
// cycle is sustained while out_tready stays high.
// The window state is updated in the cycle an item moves into the result
// register, so back-to-back items always see the state left by the one
// before.
// When the receiver holds out_tready low, the result register keeps its beat
// and the input register can still take one more beat; in_tready falls only
// when both are full.
// The synchronous reset empties both registers and loads the initial window
// state. The user writes configuration registers through cfg_wr_en, cfg_index
// and cfg_wdata while no beat is in flight; the block does not enforce it.
module congestion_window_controller
  import cwc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // ack_seq[31:0], ack_number[63:32], ack_flag[64], rtt_sample[88:65], zero fill.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command[1:0].
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // window[15:0], slow_start_threshold[31:16], packets_allowed[47:32],
  // send_base_out[79:48], retransmit_timeout[107:80], zero fill.
  output logic [OUT_DATA_W-1:0] out_tdata,
  // ack_status[1:0].
  output logic [STATUS_W-1:0]   out_tuser
);

  logic [SEQ_W-1:0] exp_seq_r, exp_seq_nxt;
  logic [WIN_W-1:0] adv_win_r, adv_win_nxt;
  cc_state_t        st_r, st_nxt, st_upd;
  cc_item_t         item_r, item_nxt;
  cc_result_t       res_r, res_nxt, res_upd;
  logic             s1_valid_r, s1_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             s2_ready, s1_load, s2_load;

  cwc_update u_update (
    .st                (st_r),
    .item              (item_r),
    .expected_peer_seq (exp_seq_r),
    .advertised_window (adv_win_r),
    .st_nxt            (st_upd),
    .res               (res_upd)
  );

  always_comb begin
    s2_ready  = !out_valid_r || out_tready;
    in_tready = !s1_valid_r || s2_ready;
    s1_load   = in_tvalid && in_tready;
    s2_load   = s1_valid_r && s2_ready;

    s1_valid_nxt  = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
    out_valid_nxt = s2_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

    item_nxt = item_r;
    if (s1_load) begin
      item_nxt.command    = in_tuser;
      item_nxt.ack_seq    = in_tdata[31:0];
      item_nxt.ack_number = in_tdata[63:32];
      item_nxt.ack_flag   = in_tdata[64];
      item_nxt.rtt_sample = in_tdata[88:65];
    end

    st_nxt  = s2_load ? st_upd : st_r;
    res_nxt = s2_load ? res_upd : res_r;

    exp_seq_nxt = exp_seq_r;
    adv_win_nxt = adv_win_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_EXPECTED_PEER_SEQ: exp_seq_nxt = cfg_wdata;
        CFG_ADVERTISED_WINDOW: adv_win_nxt = cfg_wdata[WIN_W-1:0];
        default: begin
          exp_seq_nxt = exp_seq_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      exp_seq_r           <= '0;
      adv_win_r           <= ADV_WIN_RESET;
      st_r.send_base      <= '0;
      st_r.cong_window    <= WIN_ONE;
      st_r.ss_threshold   <= '0;
      st_r.dup_acks       <= '0;
      st_r.rtt_est        <= '0;
      st_r.rtt_dev        <= {{(RTT_W-1){1'b0}}, 1'b1};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      exp_seq_r   <= exp_seq_nxt;
      adv_win_r   <= adv_win_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.ack_status;
  assign out_tdata  = {4'b0, res_r.retransmit_timeout, res_r.send_base_out,
                       res_r.packets_allowed, res_r.slow_start_threshold, res_r.window};

endmodule

/* hdl/cwc_checker.sv */
module cwc_checker
  import cwc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]   out_tuser
);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Output beat present right after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled output beat changed.");

  a_restart_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_RESTART |-> out_tdata[15:0] == WIN_ONE)
    else $error("Start or timeout did not drop the window to one packet.");

  a_allowed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] <= out_tdata[15:0])
    else $error("Packets allowed exceeds the congestion window.");

endmodule

bind congestion_window_controller cwc_checker u_cwc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* sim/tb_top.sv */
module tb_top
  import cwc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int N_DIRECTED = 20;

  typedef struct {
    cc_item_t   ev;
    bit         typed;
    cc_result_t want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // Mirror of the controller state and of its configuration registers.
  logic [SEQ_W-1:0] peer_seq_cfg;
  logic [WIN_W-1:0] adv_win_cfg;
  logic [SEQ_W-1:0] acked_base;
  logic [WIN_W-1:0] cwnd_now;
  logic [WIN_W-1:0] ssthresh_now;
  logic [DUP_W-1:0] dup_count;
  logic [RTT_W-1:0] srtt_scaled;
  logic [RTT_W-1:0] rttvar_scaled;

  cc_result_t pending_results[$];
  plan_row_t  directed_plan[N_DIRECTED];
  int         errors;
  bit         calm;

  congestion_window_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  function automatic logic [RTT_W-1:0] clamp_rtt(input longint v);
    if (v < 0) return '0;
    if (v > longint'(RTT_MAX)) return RTT_MAX;
    return v[RTT_W-1:0];
  endfunction

  function automatic logic [WIN_W-1:0] clamp_win(input longint v);
    if (v > longint'(WIN_MAX)) return WIN_MAX;
    return v[WIN_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return SAMPLE_W'($urandom_range(1, 5000));
    return SAMPLE_W'($urandom);
  endfunction

  task automatic advance_window(input cc_item_t ev, output cc_result_t res);
    longint est;
    longint dev;
    longint err;
    res.ack_status = ST_IGNORED;
    case (ev.command)
      CMD_START: begin
        cwnd_now = WIN_ONE;
        dup_count = '0;
        ssthresh_now = adv_win_cfg;
        res.ack_status = ST_RESTART;
      end
      CMD_TIMEOUT: begin
        ssthresh_now = cwnd_now >> 1;
        cwnd_now = WIN_ONE;
        dup_count = '0;
        res.ack_status = ST_RESTART;
      end
      CMD_ACK: begin
        // The smoothed estimate is refreshed on every ack, even ignored ones.
        if (srtt_scaled == '0) srtt_scaled = RTT_W'(ev.rtt_sample);
        est = longint'(srtt_scaled);
        dev = longint'(rttvar_scaled);
        err = longint'(ev.rtt_sample) - (est >>> 3);
        est = est + err;
        if (err < 0) err = -err;
        dev = dev + err - (dev >>> 3);
        srtt_scaled = clamp_rtt(est);
        rttvar_scaled = clamp_rtt(dev);
        if (ev.ack_flag && ev.ack_seq == peer_seq_cfg) begin
          if (ev.ack_number == acked_base) begin
            if (dup_count != DUP_MAX) dup_count = dup_count + 1'b1;
            if (dup_count == DUP_TRIGGER) begin
              ssthresh_now = cwnd_now >> 1;
              cwnd_now = clamp_win(longint'(ssthresh_now) + longint'(RECOVERY_ADD));
            end else if (dup_count > DUP_TRIGGER) begin
              cwnd_now = clamp_win(longint'(cwnd_now) + 1);
            end
            res.ack_status = ST_DUPLICATE;
          end else begin
            if ({cwnd_now, 1'b0} > {1'b0, ssthresh_now})
              cwnd_now = clamp_win(longint'(cwnd_now) + 1);
            else
              cwnd_now = clamp_win(longint'(cwnd_now) * 2);
            if (dup_count >= DUP_TRIGGER) cwnd_now = ssthresh_now;
            dup_count = '0;
            acked_base = ev.ack_number;
            res.ack_status = ST_NEW_ACK;
          end
        end
      end
      default: begin
      end
    endcase
    res.window = cwnd_now;
    res.slow_start_threshold = ssthresh_now;
    res.packets_allowed = (cwnd_now < adv_win_cfg) ? cwnd_now : adv_win_cfg;
    res.send_base_out = acked_base;
    res.retransmit_timeout =
      clamp_rtt(longint'(srtt_scaled >> 3) + longint'(rttvar_scaled >> 1));
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_event(input cc_item_t ev, input bit typed, input cc_result_t want);
    int gap;
    cc_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({ev.rtt_sample, ev.ack_flag, ev.ack_number, ev.ack_seq});
    in_tuser <= ev.command;
    do @(posedge clk); while (!in_tready);
    advance_window(ev, res);
    pending_results.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic wait_for_results(input int settle);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_EXPECTED_PEER_SEQ) peer_seq_cfg = value;
    else adv_win_cfg = value[WIN_W-1:0];
    @(negedge clk);
  endtask

  // Mostly well-formed ack traffic for the current peer, with dup-ack bursts
  // long enough to reach fast retransmit, plus timeouts, restarts and noise.
  task automatic send_random_traffic(input int count);
    cc_item_t ev;
    int sent;
    int kind;
    int burst;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < count) begin
      if (!paused && sent >= count / 2) begin
        wait_for_results(1);
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      ev.command = CMD_ACK;
      ev.ack_seq = peer_seq_cfg;
      ev.ack_number = acked_base;
      ev.ack_flag = 1'b1;
      burst = 1;
      if (kind < 14) begin
        ev.ack_seq = $urandom;
        ev.ack_number = $urandom;
        ev.ack_flag = 1'($urandom_range(0, 1));
        ev.command = (kind < 7) ? CMD_TIMEOUT : (kind < 11) ? CMD_START : CMD_UNUSED;
      end else if (kind < 20) begin
        ev.ack_number = $urandom;
        if ($urandom_range(0, 1)) begin
          ev.ack_flag = 1'b0;
          ev.ack_seq = $urandom;
        end else begin
          ev.ack_seq = peer_seq_cfg ^ (32'd1 << $urandom_range(0, 31));
        end
      end else if (kind < 52) begin
        burst = $urandom_range(1, 6);
      end else begin
        if ($urandom_range(0, 9) == 0) ev.ack_number = $urandom;
        else ev.ack_number = acked_base + $urandom_range(1, 3000);
        if (ev.ack_number == acked_base) ev.ack_number = acked_base + 1;
      end
      repeat (burst) begin
        ev.rtt_sample = pick_sample();
        send_event(ev, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin : ready_gen
    int hold;
    out_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %0h, got %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    cc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with none pending, status %0d window %0h",
                 $time, out_tuser, out_tdata[15:0]);
      end else begin
        want = pending_results.pop_front();
        compare_field("ack_status", 32'(want.ack_status), 32'(out_tuser));
        compare_field("window", 32'(want.window), 32'(out_tdata[15:0]));
        compare_field("slow_start_threshold", 32'(want.slow_start_threshold),
                      32'(out_tdata[31:16]));
        compare_field("packets_allowed", 32'(want.packets_allowed), 32'(out_tdata[47:32]));
        compare_field("send_base_out", want.send_base_out, out_tdata[79:48]);
        compare_field("retransmit_timeout", 32'(want.retransmit_timeout),
                      32'(out_tdata[107:80]));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    cc_item_t ev;
    logic [SEQ_W-1:0] seq_pick;
    logic [WIN_W-1:0] adv_pick;
    int extra;
    int waited;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_ACK;
    errors = 0;
    calm = 1'b0;
    peer_seq_cfg = '0;
    adv_win_cfg = ADV_WIN_RESET;
    acked_base = '0;
    cwnd_now = WIN_ONE;
    ssthresh_now = '0;
    dup_count = '0;
    srtt_scaled = '0;
    rttvar_scaled = RTT_W'(1);

    directed_plan = '{
      '{'{CMD_TIMEOUT, 32'd0, 32'd0, 1'b0, 24'd0}, 1'b1,
        '{ST_RESTART, 16'd1, 16'd0, 16'd1, 32'd0, 28'd0}},
      '{'{CMD_START, 32'd0, 32'd0, 1'b0, 24'd0}, 1'b1,
        '{ST_RESTART, 16'd1, 16'hFFFF, 16'd1, 32'd0, 28'd0}},
      '{'{CMD_ACK, 32'd0, 32'd0, 1'b0, 24'd0}, 1'b1,
        '{ST_IGNORED, 16'd1, 16'hFFFF, 16'd1, 32'd0, 28'd0}},
      '{'{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF}, 1'b1,
        '{ST_IGNORED, 16'd1, 16'hFFFF, 16'd1, 32'd0, 28'd0}},
      '{'{CMD_ACK, 32'd0, 32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF}, 1'b0, '0},
      '{'{CMD_ACK, 32'hFFFF_FFFF, 32'd0, 1'b1, 24'd1000}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'hFFFF_FFFF, 1'b1, 24'd800}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'hFFFF_FFFF, 1'b1, 24'd0}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'hFFFF_FFFF, 1'b1, 24'd1200}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'hFFFF_FFFF, 1'b1, 24'd900}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'h0000_0100, 1'b1, 24'd950}, 1'b0, '0},
      '{'{CMD_TIMEOUT, 32'd0, 32'd0, 1'b0, 24'd0}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'h0000_0100, 1'b1, 24'd400}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'h0000_0100, 1'b1, 24'd410}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'h0000_0100, 1'b1, 24'd420}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'h0000_0200, 1'b1, 24'd430}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'h0000_0300, 1'b1, 24'd440}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'd0, 1'b0, 24'd0}, 1'b0, '0},
      '{'{CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF}, 1'b0, '0},
      '{'{CMD_ACK, 32'd0, 32'h0000_0400, 1'b1, 24'd0}, 1'b0, '0}
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_event(directed_plan[i].ev, directed_plan[i].typed, directed_plan[i].want);

    // Double the window at full rate until slow start gives way to linear
    // growth, then run enough duplicates to pin the duplicate counter.
    calm = 1'b1;
    ev.command = CMD_START;
    ev.ack_seq = $urandom;
    ev.ack_number = $urandom;
    ev.ack_flag = 1'b1;
    ev.rtt_sample = pick_sample();
    send_event(ev, 1'b0, '0);
    ev.command = CMD_ACK;
    ev.ack_seq = peer_seq_cfg;
    extra = 0;
    while (extra < 4) begin
      if (cwnd_now >= 16'h8000) begin
        extra++;
        calm = 1'b0;
      end
      ev.ack_number = acked_base + $urandom_range(1, 1000);
      ev.rtt_sample = pick_sample();
      send_event(ev, 1'b0, '0);
    end
    repeat (260) begin
      ev.ack_number = acked_base;
      ev.rtt_sample = pick_sample();
      send_event(ev, 1'b0, '0);
    end

    for (int phase = 0; phase < 8; phase++) begin
      wait_for_results(4);
      seq_pick = $urandom;
      adv_pick = WIN_W'($urandom_range(1, 65535));
      case (phase)
        0: begin
          seq_pick = '1;
          adv_pick = WIN_MAX;
        end
        1: begin
          seq_pick = '0;
          adv_pick = WIN_ONE;
        end
        2: adv_pick = '0;
        4: adv_pick = WIN_W'($urandom_range(2, 16));
        default: begin
        end
      endcase
      write_reg(CFG_EXPECTED_PEER_SEQ, seq_pick);
      write_reg(CFG_ADVERTISED_WINDOW, CFG_DATA_W'(adv_pick));
      calm = (phase == 3);
      ev.command = CMD_START;
      ev.ack_seq = $urandom;
      ev.ack_number = $urandom;
      ev.ack_flag = 1'($urandom_range(0, 1));
      ev.rtt_sample = pick_sample();
      send_event(ev, 1'b0, '0);
      send_random_traffic(68);
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0t ns: %0d expected result beats never arrived",
               $time, pending_results.size());
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
